// ----- src/assert_macros.svh -----
// Assertion macros used by the checker of this project.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define C2P_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check that cons holds a fixed number of cycles after ante.
`define C2P_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("delayed implication check failed");

// Check that cons held a fixed number of cycles before ante.
`define C2P_ASSERT_PAST(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> $past((cons), dly)) \
        else $error("history check failed");

`endif

// ----- src/c2p_pkg.sv -----
package c2p_pkg;

    // Default configuration
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    // Result field widths
    localparam int DIST_WIDTH  = 20;
    localparam int ANGLE_WIDTH = 17;

    // CORDIC datapath: coordinates held with a fixed binary point at bit 60
    localparam int CORDIC_WIDTH = 64;
    localparam int CORDIC_POINT = 60;

    // Angle accumulator: degrees with 16 fraction bits
    localparam int Z_WIDTH     = 25;
    localparam int ANGLE_DROP  = 8;
    localparam int TABLE_DEPTH = 32;

    localparam logic signed [Z_WIDTH-1:0] Z_LIMIT    = 25'sd5898240;
    localparam logic signed [Z_WIDTH-1:0] Z_ROUND    = 25'sd128;

    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_HALF_TURN    = 17'sd46080;
    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_QUARTER_TURN = 17'sd23040;

    // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
    localparam logic signed [Z_WIDTH-1:0] ATAN_TABLE [TABLE_DEPTH] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0,
        25'sd0,       25'sd0,       25'sd0,      25'sd0,
        25'sd0,       25'sd0,       25'sd0,      25'sd0
    };

    // Control that travels with each word down the pipeline
    typedef struct packed {
        logic valid;
        logic neg_x;
        logic neg_y;
        logic zero_x;
        logic zero_y;
    } c2p_ctrl_t;

    // Bits of the rounded-down root of 16 * (dx^2 + dy^2)
    function automatic int root_bits(input int coord_width);
        return coord_width + 3;
    endfunction

    // Iteration stages: the longer of the rotation and the root recurrence
    function automatic int iter_stages(input int coord_width, input int cordic_steps);
        return (cordic_steps > root_bits(coord_width)) ? cordic_steps : root_bits(coord_width);
    endfunction

endpackage

// ----- src/cartesian_to_polar_distance_angle_unit.sv -----
// Channel   Handshake         Fields
// command   start / busy      x_first, y_first, x_second, y_second
// result    done              distance, angle_degrees
//
// Takes one command word every cycle; busy never rises.
// The longer of the rotation chain and the one-bit-per-stage root sets the depth.
// Reset clears every valid bit; words in flight are dropped.
// The receiver cannot hold off results, so nothing ever stalls.
module cartesian_to_polar_distance_angle_unit #(
    parameter int CORDIC_STEPS = c2p_pkg::CORDIC_STEPS_DEF,
    parameter int COORD_WIDTH  = c2p_pkg::COORD_WIDTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [COORD_WIDTH-1:0]            x_first,
    input  logic signed [COORD_WIDTH-1:0]            y_first,
    input  logic signed [COORD_WIDTH-1:0]            x_second,
    input  logic signed [COORD_WIDTH-1:0]            y_second,
    output logic                                     done,
    output logic        [c2p_pkg::DIST_WIDTH-1:0]    distance,
    output logic signed [c2p_pkg::ANGLE_WIDTH-1:0]   angle_degrees
);

    localparam int ROOT_WIDTH = c2p_pkg::root_bits(COORD_WIDTH);
    localparam int T_WIDTH    = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH  = ROOT_WIDTH + 3;
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int SQ_WIDTH   = 2 * DIFF_WIDTH;
    localparam int PRE_SHIFT  = c2p_pkg::CORDIC_POINT - COORD_WIDTH;
    localparam int N_STAGES   = c2p_pkg::iter_stages(COORD_WIDTH, CORDIC_STEPS);
    localparam int CW         = c2p_pkg::CORDIC_WIDTH;
    localparam int ZW         = c2p_pkg::Z_WIDTH;
    localparam int AW         = c2p_pkg::ANGLE_WIDTH;

    // Difference stage
    logic [DIFF_WIDTH-1:0] dx;
    logic [DIFF_WIDTH-1:0] dy;
    logic [DIFF_WIDTH-1:0] ax_next;
    logic [DIFF_WIDTH-1:0] ay_next;
    c2p_pkg::c2p_ctrl_t    diff_ctrl_next;
    c2p_pkg::c2p_ctrl_t    diff_ctrl_reg;
    logic [DIFF_WIDTH-1:0] ax_reg;
    logic [DIFF_WIDTH-1:0] ay_reg;

    assign busy = 1'b0;

    always_comb
    begin
        dx      = {x_second[COORD_WIDTH-1], x_second} - {x_first[COORD_WIDTH-1], x_first};
        dy      = {y_second[COORD_WIDTH-1], y_second} - {y_first[COORD_WIDTH-1], y_first};
        ax_next = dx[DIFF_WIDTH-1] ? (~dx + 1'b1) : dx;
        ay_next = dy[DIFF_WIDTH-1] ? (~dy + 1'b1) : dy;
        diff_ctrl_next.valid  = start && !busy;
        diff_ctrl_next.neg_x  = dx[DIFF_WIDTH-1];
        diff_ctrl_next.neg_y  = dy[DIFF_WIDTH-1];
        diff_ctrl_next.zero_x = (dx == '0);
        diff_ctrl_next.zero_y = (dy == '0);
    end

    // Square stage
    c2p_pkg::c2p_ctrl_t  sq_ctrl_reg;
    logic [SQ_WIDTH-1:0] sq_x_reg;
    logic [SQ_WIDTH-1:0] sq_y_reg;
    logic [DIFF_WIDTH-1:0] sq_ax_reg;
    logic [DIFF_WIDTH-1:0] sq_ay_reg;

    // Initial stage of both recurrences
    c2p_pkg::c2p_ctrl_t      init_ctrl_reg;
    logic [T_WIDTH-1:0]      t_init_next;
    logic signed [CW-1:0]    x_init_next;
    logic signed [CW-1:0]    y_init_next;
    logic [T_WIDTH-1:0]      t_init_reg;
    logic signed [CW-1:0]    x_init_reg;
    logic signed [CW-1:0]    y_init_reg;

    always_comb
    begin
        t_init_next = (T_WIDTH'(sq_x_reg) + T_WIDTH'(sq_y_reg)) << 4;
        x_init_next = CW'(sq_ax_reg) << PRE_SHIFT;
        y_init_next = CW'(sq_ay_reg) << PRE_SHIFT;
    end

    // Hold control of the front stages under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_ctrl_reg <= '0;
            sq_ctrl_reg   <= '0;
            init_ctrl_reg <= '0;
        end
        else
        begin
            diff_ctrl_reg <= diff_ctrl_next;
            sq_ctrl_reg   <= diff_ctrl_reg;
            init_ctrl_reg <= sq_ctrl_reg;
        end
    end

    // Advance the front-stage payload
    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        sq_x_reg   <= ax_reg * ax_reg;
        sq_y_reg   <= ay_reg * ay_reg;
        sq_ax_reg  <= ax_reg;
        sq_ay_reg  <= ay_reg;
        t_init_reg <= t_init_next;
        x_init_reg <= x_init_next;
        y_init_reg <= y_init_next;
    end

    // Iteration stages
    c2p_pkg::c2p_ctrl_t   ctrl_pipe [0:N_STAGES];
    logic signed [CW-1:0] x_pipe    [0:N_STAGES];
    logic signed [CW-1:0] y_pipe    [0:N_STAGES];
    logic signed [ZW-1:0] z_pipe    [0:N_STAGES];
    logic [T_WIDTH-1:0]   t_pipe    [0:N_STAGES];
    logic [REM_WIDTH-1:0] rem_pipe  [0:N_STAGES];
    logic [ROOT_WIDTH-1:0] root_pipe [0:N_STAGES];

    assign ctrl_pipe[0] = init_ctrl_reg;
    assign x_pipe[0]    = x_init_reg;
    assign y_pipe[0]    = y_init_reg;
    assign z_pipe[0]    = '0;
    assign t_pipe[0]    = t_init_reg;
    assign rem_pipe[0]  = '0;
    assign root_pipe[0] = '0;

    generate
        for (genvar k = 0; k < N_STAGES; k++)
        begin : g_stage
            c2p_iter_stage #(
                .STEP_INDEX   (k),
                .CORDIC_STEPS (CORDIC_STEPS),
                .ROOT_WIDTH   (ROOT_WIDTH)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl_in  (ctrl_pipe[k]),
                .x_in     (x_pipe[k]),
                .y_in     (y_pipe[k]),
                .z_in     (z_pipe[k]),
                .t_in     (t_pipe[k]),
                .rem_in   (rem_pipe[k]),
                .root_in  (root_pipe[k]),
                .ctrl_out (ctrl_pipe[k+1]),
                .x_out    (x_pipe[k+1]),
                .y_out    (y_pipe[k+1]),
                .z_out    (z_pipe[k+1]),
                .t_out    (t_pipe[k+1]),
                .rem_out  (rem_pipe[k+1]),
                .root_out (root_pipe[k+1])
            );
        end
    endgenerate

    // Output stage: round the root, clamp and fold the angle
    c2p_pkg::c2p_ctrl_t          fin_ctrl;
    logic                        round_up;
    logic [ROOT_WIDTH:0]         dist_full;
    logic [c2p_pkg::DIST_WIDTH-1:0] distance_next;
    logic signed [ZW-1:0]        z_fin;
    logic [ZW-1:0]               z_clamped;
    logic [ZW-1:0]               z_rounded;
    logic signed [AW-1:0]        angle_first;
    logic signed [AW-1:0]        angle_half;
    logic signed [AW-1:0]        angle_next;
    logic                        done_reg;
    logic [c2p_pkg::DIST_WIDTH-1:0] distance_reg;
    logic signed [AW-1:0]        angle_reg;

    always_comb
    begin
        fin_ctrl = ctrl_pipe[N_STAGES];

        // Round to nearest: step up when the remainder exceeds the root
        round_up      = rem_pipe[N_STAGES] > REM_WIDTH'(root_pipe[N_STAGES]);
        dist_full     = (ROOT_WIDTH + 1)'(root_pipe[N_STAGES]) + (ROOT_WIDTH + 1)'(round_up);
        distance_next = c2p_pkg::DIST_WIDTH'(dist_full);

        // Clamp the accumulator to the first quadrant, then drop to 1/256 degree
        z_fin = z_pipe[N_STAGES];
        if (z_fin[ZW-1])
        begin
            z_clamped = '0;
        end
        else if (z_fin > c2p_pkg::Z_LIMIT)
        begin
            z_clamped = c2p_pkg::Z_LIMIT;
        end
        else
        begin
            z_clamped = z_fin;
        end
        z_rounded = z_clamped + c2p_pkg::Z_ROUND;

        // Axis cases are exact
        if (fin_ctrl.zero_y)
        begin
            angle_first = '0;
        end
        else if (fin_ctrl.zero_x)
        begin
            angle_first = c2p_pkg::ANGLE_QUARTER_TURN;
        end
        else
        begin
            angle_first = AW'(z_rounded >> c2p_pkg::ANGLE_DROP);
        end

        // Fold into the quadrant of (dx, dy)
        angle_half = fin_ctrl.neg_x ? (c2p_pkg::ANGLE_HALF_TURN - angle_first) : angle_first;
        angle_next = fin_ctrl.neg_y ? -angle_half : angle_half;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= distance_next;
        angle_reg    <= angle_next;
    end

    assign done          = done_reg;
    assign distance      = distance_reg;
    assign angle_degrees = angle_reg;

endmodule

// ----- src/c2p_iter_stage.sv -----
module c2p_iter_stage #(
    parameter int STEP_INDEX   = 0,
    parameter int CORDIC_STEPS = c2p_pkg::CORDIC_STEPS_DEF,
    parameter int ROOT_WIDTH   = c2p_pkg::COORD_WIDTH_DEF + 3
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  c2p_pkg::c2p_ctrl_t                        ctrl_in,
    input  logic signed [c2p_pkg::CORDIC_WIDTH-1:0]   x_in,
    input  logic signed [c2p_pkg::CORDIC_WIDTH-1:0]   y_in,
    input  logic signed [c2p_pkg::Z_WIDTH-1:0]        z_in,
    input  logic        [2*ROOT_WIDTH-1:0]            t_in,
    input  logic        [ROOT_WIDTH+2:0]              rem_in,
    input  logic        [ROOT_WIDTH-1:0]              root_in,
    output c2p_pkg::c2p_ctrl_t                        ctrl_out,
    output logic signed [c2p_pkg::CORDIC_WIDTH-1:0]   x_out,
    output logic signed [c2p_pkg::CORDIC_WIDTH-1:0]   y_out,
    output logic signed [c2p_pkg::Z_WIDTH-1:0]        z_out,
    output logic        [2*ROOT_WIDTH-1:0]            t_out,
    output logic        [ROOT_WIDTH+2:0]              rem_out,
    output logic        [ROOT_WIDTH-1:0]              root_out
);

    localparam int T_WIDTH   = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH = ROOT_WIDTH + 3;

    c2p_pkg::c2p_ctrl_t                      ctrl_reg;
    logic signed [c2p_pkg::CORDIC_WIDTH-1:0] x_next;
    logic signed [c2p_pkg::CORDIC_WIDTH-1:0] y_next;
    logic signed [c2p_pkg::Z_WIDTH-1:0]      z_next;
    logic signed [c2p_pkg::CORDIC_WIDTH-1:0] x_reg;
    logic signed [c2p_pkg::CORDIC_WIDTH-1:0] y_reg;
    logic signed [c2p_pkg::Z_WIDTH-1:0]      z_reg;
    logic [T_WIDTH-1:0]                      t_next;
    logic [REM_WIDTH-1:0]                    rem_next;
    logic [ROOT_WIDTH-1:0]                   root_next;
    logic [T_WIDTH-1:0]                      t_reg;
    logic [REM_WIDTH-1:0]                    rem_reg;
    logic [ROOT_WIDTH-1:0]                   root_reg;

    // One micro-rotation towards the x axis
    generate
        if (STEP_INDEX < CORDIC_STEPS)
        begin : g_rotate
            logic signed [c2p_pkg::CORDIC_WIDTH-1:0] x_shift;
            logic signed [c2p_pkg::CORDIC_WIDTH-1:0] y_shift;
            logic                                    y_pos;

            always_comb
            begin
                x_shift = x_in >>> STEP_INDEX;
                y_shift = y_in >>> STEP_INDEX;
                y_pos   = !y_in[c2p_pkg::CORDIC_WIDTH-1] && (y_in != '0);
                if (y_pos)
                begin
                    x_next = x_in + y_shift;
                    y_next = y_in - x_shift;
                    z_next = z_in + c2p_pkg::ATAN_TABLE[STEP_INDEX];
                end
                else
                begin
                    x_next = x_in - y_shift;
                    y_next = y_in + x_shift;
                    z_next = z_in - c2p_pkg::ATAN_TABLE[STEP_INDEX];
                end
            end
        end
        else
        begin : g_rotate_hold
            always_comb
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = z_in;
            end
        end
    endgenerate

    // One root bit from the next pair of radicand bits
    generate
        if (STEP_INDEX < ROOT_WIDTH)
        begin : g_root
            logic [REM_WIDTH-1:0] rem_shift;
            logic [REM_WIDTH-1:0] trial;

            always_comb
            begin
                rem_shift = {rem_in[REM_WIDTH-3:0], t_in[T_WIDTH-1 -: 2]};
                trial     = {1'b0, root_in, 2'b01};
                t_next    = {t_in[T_WIDTH-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_in[ROOT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_in[ROOT_WIDTH-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_root_hold
            always_comb
            begin
                t_next    = t_in;
                rem_next  = rem_in;
                root_next = root_in;
            end
        end
    endgenerate

    // Advance the control word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        t_reg    <= t_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign t_out    = t_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ----- src/c2p_checker.sv -----
`include "assert_macros.svh"

module c2p_checker #(
    parameter int CORDIC_STEPS = c2p_pkg::CORDIC_STEPS_DEF,
    parameter int COORD_WIDTH  = c2p_pkg::COORD_WIDTH_DEF
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   done,
    input logic        [c2p_pkg::DIST_WIDTH-1:0]  distance,
    input logic signed [c2p_pkg::ANGLE_WIDTH-1:0] angle_degrees
);

    localparam int LATENCY = c2p_pkg::iter_stages(COORD_WIDTH, CORDIC_STEPS) + 4;

    logic angle_in_range;

    // Angle within one half turn either way
    assign angle_in_range = (angle_degrees <= c2p_pkg::ANGLE_HALF_TURN)
                         && (angle_degrees >= -c2p_pkg::ANGLE_HALF_TURN);

    // Every accepted word comes out after the fixed latency
    `C2P_ASSERT_DELAY(a_word_out, start && !busy, LATENCY, done)

    // No result without a word accepted at the matching cycle
    `C2P_ASSERT_PAST(a_no_phantom, done, LATENCY, start && !busy)

    // Angle stays within one half turn either way
    `C2P_ASSERT_IMPLY(a_angle_range, done, angle_in_range)

    // Coincident points give a zero angle
    `C2P_ASSERT_IMPLY(a_zero_angle, done && (distance == '0), angle_degrees == '0)

endmodule

bind cartesian_to_polar_distance_angle_unit c2p_checker #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_WIDTH  (COORD_WIDTH)
) u_c2p_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .distance      (distance),
    .angle_degrees (angle_degrees)
);

// ----- tb/sv/tb.sv -----
module tb;

    localparam int CLOCK_HALF    = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int PIPE_LATENCY  = 23;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 8;
    localparam int RUN_LIMIT     = 2_000_000;
    localparam int COORD_W       = c2p_pkg::COORD_WIDTH_DEF;

    // Predictor constants: rotation steps, binary point shift and angle scaling
    localparam int     ROT_STEPS    = 18;
    localparam int     POINT_SHIFT  = 60 - COORD_W;
    localparam longint ACC_LIMIT    = longint'(90) << 16;
    localparam longint ACC_ROUND    = 128;
    localparam longint HALF_TURN    = 46080;
    localparam longint QUARTER_TURN = 23040;

    typedef struct {
        logic        [c2p_pkg::DIST_WIDTH-1:0]  distance;
        logic signed [c2p_pkg::ANGLE_WIDTH-1:0] angle_degrees;
    } polar_t;

    // atan(2^-i) in degrees with 16 fraction bits
    longint arctan_deg [ROT_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
    };

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [COORD_W-1:0] x_first;
    logic signed [COORD_W-1:0] y_first;
    logic signed [COORD_W-1:0] x_second;
    logic signed [COORD_W-1:0] y_second;
    logic done;
    logic        [c2p_pkg::DIST_WIDTH-1:0]  distance;
    logic signed [c2p_pkg::ANGLE_WIDTH-1:0] angle_degrees;

    polar_t expected_polar[$];
    int     failures;
    bit     full_rate;

    cartesian_to_polar_distance_angle_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .x_first       (x_first),
        .y_first       (y_first),
        .x_second      (x_second),
        .y_second      (y_second),
        .done          (done),
        .distance      (distance),
        .angle_degrees (angle_degrees)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #(CLOCK_HALF) clk = ~clk;

    // Distance and direction of the second point seen from the first
    function automatic polar_t predict_polar(input logic signed [COORD_W-1:0] x1,
                                             input logic signed [COORD_W-1:0] y1,
                                             input logic signed [COORD_W-1:0] x2,
                                             input logic signed [COORD_W-1:0] y2);
        longint dx, dy, ax, ay;
        longint rx, ry, acc, sx, sy, turn;
        longint unsigned square, root, trial;
        int     b;
        int     i;
        polar_t res;
        dx = longint'(x2) - longint'(x1);
        dy = longint'(y2) - longint'(y1);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;

        // Root of 16 * (dx^2 + dy^2), bit by bit, then round to nearest
        square = 64'(16 * (ax * ax + ay * ay));
        root = 0;
        for (b = 21; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= square)
                root = trial;
        end
        if (root * root + root + 1 <= square)
            root = root + 1;

        // First-quadrant angle: exact on the axes, vectoring rotation elsewhere
        if (ay == 0)
            turn = 0;
        else if (ax == 0)
            turn = QUARTER_TURN;
        else
        begin
            rx  = ax << POINT_SHIFT;
            ry  = ay << POINT_SHIFT;
            acc = 0;
            for (i = 0; i < ROT_STEPS; i++)
            begin
                sx = rx >>> i;
                sy = ry >>> i;
                if (ry > 0)
                begin
                    rx  = rx + sy;
                    ry  = ry - sx;
                    acc = acc + arctan_deg[i];
                end
                else
                begin
                    rx  = rx - sy;
                    ry  = ry + sx;
                    acc = acc - arctan_deg[i];
                end
            end
            if (acc < 0)
                acc = 0;
            if (acc > ACC_LIMIT)
                acc = ACC_LIMIT;
            turn = (acc + ACC_ROUND) >>> 8;
        end

        // Fold into the quadrant of (dx, dy)
        if (dx < 0)
            turn = HALF_TURN - turn;
        if (dy < 0)
            turn = -turn;

        res.distance      = root[c2p_pkg::DIST_WIDTH-1:0];
        res.angle_degrees = turn[c2p_pkg::ANGLE_WIDTH-1:0];
        return res;
    endfunction

    // Idle cycles after a word: mostly none or a few, now and then a long pause
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (full_rate || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Offer one command word, hold it until taken, log its expected result
    task automatic send_word(input logic signed [COORD_W-1:0] x1,
                             input logic signed [COORD_W-1:0] y1,
                             input logic signed [COORD_W-1:0] x2,
                             input logic signed [COORD_W-1:0] y2);
        int gap;
        @(negedge clk);
        start    <= 1'b1;
        x_first  <= x1;
        y_first  <= y1;
        x_second <= x2;
        y_second <= y2;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_polar.push_back(predict_polar(x1, y1, x2, y2));
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_polar.size() == 0)
            begin
                $error("result word with no command outstanding");
                failures++;
            end
            else
            begin
                automatic polar_t exp_word = expected_polar.pop_front();
                if (distance !== exp_word.distance)
                begin
                    $error("distance: expected %0d, got %0d", exp_word.distance, distance);
                    failures++;
                end
                if (angle_degrees !== exp_word.angle_degrees)
                begin
                    $error("angle_degrees: expected %0d, got %0d",
                           exp_word.angle_degrees, angle_degrees);
                    failures++;
                end
            end
        end
    end

    // Extremes of every field, each quadrant, the axes and the zero vector
    task automatic test_corner_words();
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(16'sd1234, -16'sd4321, 16'sd1234, -16'sd4321);
        send_word(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_word(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_word(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        send_word(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
        send_word(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);
        send_word(16'sd32767, 16'sd5, -16'sd32768, 16'sd5);
        send_word(16'sd7, -16'sd32768, 16'sd7, 16'sd32767);
        send_word(-16'sd9, 16'sd32767, -16'sd9, -16'sd32768);
        send_word(16'sd0, 16'sd0, 16'sd1, 16'sd0);
        send_word(16'sd0, 16'sd0, -16'sd1, 16'sd0);
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd1);
        send_word(16'sd0, 16'sd0, 16'sd0, -16'sd1);
        send_word(16'sd0, 16'sd0, 16'sd1, 16'sd1);
        send_word(16'sd0, 16'sd0, -16'sd1, 16'sd1);
        send_word(16'sd0, 16'sd0, -16'sd1, -16'sd1);
        send_word(16'sd0, 16'sd0, 16'sd1, -16'sd1);
        send_word(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32767);
        send_word(-16'sd32768, -16'sd32768, -16'sd32767, 16'sd32767);
        send_word(16'sd32767, 16'sd32767, -16'sd32767, 16'sd32766);
        send_word(16'sd100, 16'sd200, 16'sd103, 16'sd204);
        send_word(-16'sd21846, 16'sd21845, 16'sd21845, -16'sd21846);
    endtask

    // Every coordinate drawn over its whole range
    task automatic test_uniform_words(input int count);
        logic signed [COORD_W-1:0] x1, y1, x2, y2;
        repeat (count)
        begin
            x1 = COORD_W'($urandom);
            y1 = COORD_W'($urandom);
            x2 = COORD_W'($urandom);
            y2 = COORD_W'($urandom);
            send_word(x1, y1, x2, y2);
        end
    endtask

    // Points close together: short vectors stress rounding of both results
    task automatic test_near_words(input int count);
        logic signed [COORD_W-1:0] x1, y1, x2, y2;
        repeat (count)
        begin
            x1 = COORD_W'($urandom);
            y1 = COORD_W'($urandom);
            x2 = COORD_W'(x1 + ($urandom_range(32) - 16));
            y2 = COORD_W'(y1 + ($urandom_range(32) - 16));
            send_word(x1, y1, x2, y2);
        end
    endtask

    // Vectors on the axes, on the diagonals, nearly so, or of zero length
    task automatic test_axis_words(input int count);
        logic signed [COORD_W-1:0] x1, y1, x2, y2;
        int d, e;
        repeat (count)
        begin
            x1 = COORD_W'($urandom_range(32767) - 16384);
            y1 = COORD_W'($urandom_range(32767) - 16384);
            d  = $urandom_range(32767) - 16384;
            e  = $urandom_range(2) - 1;
            case ($urandom_range(4))
                0:
                begin
                    x2 = COORD_W'(x1 + d);
                    y2 = y1;
                end
                1:
                begin
                    x2 = x1;
                    y2 = COORD_W'(y1 + d);
                end
                2:
                begin
                    x2 = COORD_W'(x1 + d);
                    y2 = ($urandom_range(1) != 0) ? COORD_W'(y1 + d) : COORD_W'(y1 - d);
                end
                3:
                begin
                    x2 = COORD_W'(x1 + d);
                    y2 = COORD_W'(y1 + e);
                end
                default:
                begin
                    x2 = x1;
                    y2 = y1;
                end
            endcase
            send_word(x1, y1, x2, y2);
        end
    endtask

    // Back-to-back words with no idle cycles at all
    task automatic test_full_rate_words(input int count);
        full_rate = 1'b1;
        test_uniform_words(count / 2);
        test_near_words(count - count / 2);
        full_rate = 1'b0;
    endtask

    // Reset, run each test in turn, drain the pipeline and report
    initial
    begin
        failures  = 0;
        full_rate = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        x_first   = '0;
        y_first   = '0;
        x_second  = '0;
        y_second  = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_words();
        test_uniform_words(300);
        test_near_words(180);
        test_axis_words(120);
        test_full_rate_words(130);

        @(negedge clk);
        start <= 1'b0;
        while (expected_polar.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/c2p_pkg.sv
src/c2p_iter_stage.sv
src/cartesian_to_polar_distance_angle_unit.sv
src/c2p_checker.sv
tb/sv/tb.sv
